>>> rtl/core/xorshift_random_word_generator_defines.svh
// Assertion macros for the random word generator.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef XORSHIFT_RANDOM_WORD_GENERATOR_DEFINES_SVH
`define XORSHIFT_RANDOM_WORD_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define XRWG_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// cons must hold in the cycle after ante
`define XRWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XRWG_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define XRWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/xrwg_pkg.sv
package xrwg_pkg;

    // word and ring geometry
    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int RING_WORDS = 16;
    localparam int POS_W      = $clog2(RING_WORDS);
    localparam int OP_W       = 2;
    localparam int IDX_W      = 4;
    localparam int S_TDATA_W  = ((IDX_W + WORD_W + 7) / 8) * 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item op codes
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW    = 2'd2;

    // configuration register indexes
    localparam logic REG_LONG_MODE   = 1'b0;
    localparam logic REG_OUTPUT_MULT = 1'b1;

    localparam logic [WORD_W-1:0] MULT_RESET = 64'd1181783497276652981;

    // xorshift shift amounts
    localparam int SH128_A  = 23;
    localparam int SH128_B  = 18;
    localparam int SH128_C  = 5;
    localparam int SH1024_A = 31;
    localparam int SH1024_B = 11;
    localparam int SH1024_C = 30;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  seed_index;
        logic [WORD_W-1:0] seed_value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic             pop;
        logic             long_draw;
        logic [POS_W-1:0] ring_pos;
    } back_status_t;

endpackage

>>> rtl/core/xrwg_front.sv
module xrwg_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [xrwg_pkg::S_TDATA_W-1:0]     s_tdata,   // seed_index, seed_value, zero pad
    input  logic [xrwg_pkg::OP_W-1:0]          s_tuser,   // op
    input  xrwg_pkg::q_status_t                q_stat,
    output logic                               push,
    output xrwg_pkg::cmd_t                     cmd
);

    // take a beat whenever the queue has room
    assign s_tready = !q_stat.full;

    assign cmd.op         = s_tuser;
    assign cmd.seed_index = s_tdata[xrwg_pkg::IDX_W-1:0];
    assign cmd.seed_value = s_tdata[xrwg_pkg::IDX_W +: xrwg_pkg::WORD_W];

    // classify: unused op code is swallowed here
    always_comb begin
        unique case (s_tuser)
            xrwg_pkg::OP_LOAD,
            xrwg_pkg::OP_RESTART,
            xrwg_pkg::OP_DRAW: push = s_tvalid && s_tready;
            default:           push = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/xrwg_queue.sv
module xrwg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  xrwg_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output xrwg_pkg::cmd_t      head,
    output xrwg_pkg::q_status_t q_stat
);

    xrwg_pkg::cmd_t                  entry_reg [xrwg_pkg::QUEUE_DEPTH];
    logic [xrwg_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [xrwg_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [xrwg_pkg::QCNT_W-1:0]     count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == xrwg_pkg::QCNT_W'(xrwg_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/xrwg_mul.sv
module xrwg_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic                           in_long,
    input  logic [xrwg_pkg::WORD_W-1:0]    in_word,
    input  logic [xrwg_pkg::WORD_W-1:0]    mult,
    output logic                           out_valid,
    output logic [xrwg_pkg::WORD_W-1:0]    out_word
);

    localparam int H = xrwg_pkg::HALF_W;

    logic                          pp_valid_reg;
    logic [xrwg_pkg::WORD_W-1:0]   pp_lo_reg;
    logic [H-1:0]                  pp_x1_reg;
    logic [H-1:0]                  pp_x2_reg;
    logic                          out_valid_reg;
    logic [xrwg_pkg::WORD_W-1:0]   out_word_reg;
    logic [xrwg_pkg::WORD_W-1:0]   prod_ll;
    logic [xrwg_pkg::WORD_W-1:0]   prod_lh;
    logic [xrwg_pkg::WORD_W-1:0]   prod_hl;
    logic [H-1:0]                  cross_sum;

    // 32x32 partial products; only the low half of the cross terms matters mod 2^64
    assign prod_ll = in_word[H-1:0] * mult[H-1:0];
    assign prod_lh = in_word[H-1:0] * mult[xrwg_pkg::WORD_W-1:H];
    assign prod_hl = in_word[xrwg_pkg::WORD_W-1:H] * mult[H-1:0];

    assign cross_sum = pp_x1_reg + pp_x2_reg;

    // valid bits of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            pp_valid_reg  <= in_valid;
            out_valid_reg <= pp_valid_reg;
        end
    end

    // product stage (short-mode words pass through unmultiplied), then final sum into the output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (in_long) begin
                pp_lo_reg <= prod_ll;
                pp_x1_reg <= prod_lh[H-1:0];
                pp_x2_reg <= prod_hl[H-1:0];
            end else begin
                pp_lo_reg <= in_word;
                pp_x1_reg <= '0;
                pp_x2_reg <= '0;
            end
            out_word_reg <= pp_lo_reg + {cross_sum, {H{1'b0}}};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> rtl/core/xrwg_back.sv
module xrwg_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               long_mode,
    input  logic [xrwg_pkg::WORD_W-1:0]        mult,
    input  xrwg_pkg::cmd_t                     head,
    input  xrwg_pkg::q_status_t                q_stat,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xrwg_pkg::WORD_W-1:0]        m_tdata,   // random_word
    output xrwg_pkg::back_status_t             b_stat
);

    localparam int W = xrwg_pkg::WORD_W;

    logic [W-1:0]                seed_reg [xrwg_pkg::RING_WORDS];
    logic [W-1:0]                work_reg [xrwg_pkg::RING_WORDS];
    logic [W-1:0]                cur_reg;      // copy of work_reg[ring_pos_reg]
    logic [xrwg_pkg::POS_W-1:0]  ring_pos_reg;
    logic [xrwg_pkg::POS_W-1:0]  ring_pos_next;
    logic                        ex_valid_reg;
    logic                        ex_long_reg;
    logic [W-1:0]                ex_word_reg;

    logic                        adv;
    logic                        is_draw;
    logic [W-1:0]                s_x;
    logic [W-1:0]                s_y;
    logic [W-1:0]                s_new;
    logic [W-1:0]                s_sum;
    logic [W-1:0]                l_y;
    logic [W-1:0]                l_new;

    // draw pipe moves when the output register is empty or being taken; load and restart pop even when it stalls
    assign adv     = !m_tvalid || m_tready;
    assign is_draw = (head.op == xrwg_pkg::OP_DRAW);
    assign pop     = !q_stat.empty && (adv || !is_draw);

    // xorshift128+ step on words 0 and 1
    assign s_x   = work_reg[0] ^ (work_reg[0] << xrwg_pkg::SH128_A);
    assign s_y   = work_reg[1];
    assign s_new = s_x ^ s_y ^ (s_x >> xrwg_pkg::SH128_B) ^ (s_y >> xrwg_pkg::SH128_C);
    assign s_sum = s_new + s_y;

    // xorshift1024* step: old word from cur_reg, next word from the ring
    assign ring_pos_next = ring_pos_reg + 1'b1;
    assign l_y   = work_reg[ring_pos_next] ^ (work_reg[ring_pos_next] << xrwg_pkg::SH1024_A);
    assign l_new = l_y ^ cur_reg ^ (l_y >> xrwg_pkg::SH1024_B)
                 ^ (cur_reg >> xrwg_pkg::SH1024_C);

    // generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < xrwg_pkg::RING_WORDS; i++) begin
                seed_reg[i] <= '0;
                work_reg[i] <= '0;
            end
            cur_reg      <= '0;
            ring_pos_reg <= '0;
        end else if (pop) begin
            unique case (head.op)
                xrwg_pkg::OP_LOAD: begin
                    seed_reg[head.seed_index] <= head.seed_value;
                end
                xrwg_pkg::OP_RESTART: begin
                    work_reg <= seed_reg;
                    cur_reg  <= seed_reg[ring_pos_reg];
                end
                xrwg_pkg::OP_DRAW: begin
                    if (long_mode) begin
                        work_reg[ring_pos_next] <= l_new;
                        cur_reg                 <= l_new;
                        ring_pos_reg            <= ring_pos_next;
                    end else begin
                        work_reg[0] <= s_y;
                        work_reg[1] <= s_new;
                        // keep the ring copy coherent with the touched words
                        if (ring_pos_reg == xrwg_pkg::POS_W'(0)) begin
                            cur_reg <= s_y;
                        end else if (ring_pos_reg == xrwg_pkg::POS_W'(1)) begin
                            cur_reg <= s_new;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // execute stage register feeding the multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (adv) begin
            ex_valid_reg <= pop && is_draw;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ex_long_reg <= long_mode;
            ex_word_reg <= long_mode ? l_new : s_sum;
        end
    end

    xrwg_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (ex_valid_reg),
        .in_long   (ex_long_reg),
        .in_word   (ex_word_reg),
        .mult      (mult),
        .out_valid (m_tvalid),
        .out_word  (m_tdata)
    );

    assign b_stat.pop       = pop;
    assign b_stat.long_draw = pop && is_draw && long_mode;
    assign b_stat.ring_pos  = ring_pos_reg;

endmodule

>>> rtl/core/xorshift_random_word_generator.sv
// A draw beat passes from the command queue through the execute register (with the
// state update), the partial products and the final sum before it shows on m_tdata.
// Throughput: one beat per cycle on both sides while the queue has room and m_tready
// is high; the 4-entry command queue lets input and output stall independently.
// Reset (aresetn low, synchronous): seed and working words clear to zero,
// ring position 0, 128-bit mode, multiplier back to its default.
`include "xorshift_random_word_generator_defines.svh"

module xorshift_random_word_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [xrwg_pkg::S_TDATA_W-1:0]     s_tdata,   // seed_index, seed_value, zero pad
    input  logic [xrwg_pkg::OP_W-1:0]          s_tuser,   // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xrwg_pkg::WORD_W-1:0]        m_tdata,   // random_word
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [xrwg_pkg::WORD_W-1:0]        cfg_data
);

    logic                          long_mode_reg;
    logic [xrwg_pkg::WORD_W-1:0]   mult_reg;
    logic                          push;
    logic                          pop;
    xrwg_pkg::cmd_t                push_cmd;
    xrwg_pkg::cmd_t                head;
    xrwg_pkg::q_status_t           q_stat;
    xrwg_pkg::back_status_t        b_stat;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_mode_reg <= 1'b0;
            mult_reg      <= xrwg_pkg::MULT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                xrwg_pkg::REG_LONG_MODE:   long_mode_reg <= cfg_data[0];
                xrwg_pkg::REG_OUTPUT_MULT: mult_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    xrwg_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .cmd      (push_cmd)
    );

    xrwg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    xrwg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .long_mode (long_mode_reg),
        .mult      (mult_reg),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .b_stat    (b_stat)
    );

    // checks
    `XRWG_ASSERT_ALWAYS(a_queue_flags, aclk, aresetn,
        !(q_stat.full && q_stat.empty), "queue full and empty")
    `XRWG_ASSERT_ALWAYS(a_no_pop_empty, aclk, aresetn,
        !(b_stat.pop && q_stat.empty), "pop from empty queue")
    `XRWG_ASSERT_ALWAYS(a_no_accept_full, aclk, aresetn,
        !(s_tready && q_stat.full), "ready while queue full")
    `XRWG_ASSERT_NEXT(a_ring_hold, aclk, aresetn, !b_stat.long_draw,
        b_stat.ring_pos == $past(b_stat.ring_pos), "ring moved without long draw")

endmodule
